// ===== hdl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the port to socket table: table geometry,
// request and status codes, the stored entry and the request/result words.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int HANDLE_BITS   = 32;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  localparam int KIND_W       = 2;
  localparam int PORT_W       = 16;
  localparam int IN_HANDLE_W  = 32;
  localparam int STATUS_W     = 2;
  localparam int OUT_HANDLE_W = 32;

  localparam int IN_FIELDS_W  = PORT_W + IN_HANDLE_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STATUS_W + 1 + OUT_HANDLE_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } pts_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_FULL = 2'd2,
    STAT_RSVD = 2'd3
  } pts_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WB
  } pts_state_t;

  typedef struct packed {
    logic [PORT_W-1:0]      port;
    logic [HANDLE_BITS-1:0] handle;
  } pts_entry_t;

  localparam int ENTRY_W = $bits(pts_entry_t);

  typedef struct packed {
    pts_kind_t              kind;
    logic [PORT_W-1:0]      port;
    logic [HANDLE_BITS-1:0] handle;
  } pts_req_t;

  typedef struct packed {
    pts_status_t             status;
    logic                    found;
    logic [OUT_HANDLE_W-1:0] handle_out;
  } pts_result_t;

endpackage

// ===== hdl/pts_ram.sv =====
// ----------------------------------------------------------------------------
// pts_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module pts_ram #(
  parameter  int DEPTH  = 64,
  parameter  int WIDTH  = 48,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/pts_engine.sv =====
// ----------------------------------------------------------------------------
// pts_engine
// Request sequencer: scans every table slot through the entry RAM, keeps the
// first port match, the lowest free slot and the lowest-port handle match,
// then writes the table back and hands one result to the output register.
// ----------------------------------------------------------------------------
module pts_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  pts_pkg::pts_req_t    req,
  output logic                 res_valid,
  input  logic                 res_ready,
  output pts_pkg::pts_result_t res
);
  import pts_pkg::*;

  pts_state_t state_r, state_nxt;

  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]         addr_r, addr_nxt;
  logic                     cmp_en_r, cmp_en_nxt;
  logic [IDX_W-1:0]         cmp_addr_r, cmp_addr_nxt;
  pts_req_t                 req_r, req_nxt;

  logic                     hit_r, hit_nxt;
  logic [HANDLE_BITS-1:0]   hit_handle_r, hit_handle_nxt;
  logic                     free_r, free_nxt;
  logic [IDX_W-1:0]         free_idx_r, free_idx_nxt;
  logic                     best_r, best_nxt;
  logic [IDX_W-1:0]         best_idx_r, best_idx_nxt;
  logic [PORT_W-1:0]        best_port_r, best_port_nxt;

  logic                     rd_en;
  logic [ENTRY_W-1:0]       rd_word;
  pts_entry_t               rd_entry;
  logic                     ram_we;
  pts_entry_t               wr_entry;
  logic                     scan_last;
  logic                     wb_fire;
  logic                     slot_valid;

  assign rd_entry  = pts_entry_t'(rd_word);
  assign scan_last = (addr_r == IDX_W'(TABLE_ENTRIES - 1));
  assign wb_fire   = (state_r == ST_WB) && res_ready;
  assign slot_valid = valid_r[cmp_addr_r];
  assign wr_entry  = '{port: req_r.port, handle: req_r.handle};

  pts_ram #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (free_idx_r),
    .wr_data (ENTRY_W'(wr_entry)),
    .rd_en   (rd_en),
    .rd_addr (addr_r),
    .rd_data (rd_word)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_WB;
      ST_WB: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    req_ready = 1'b0;
    rd_en     = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      ST_IDLE:  req_ready = 1'b1;
      ST_SCAN:  rd_en     = 1'b1;
      ST_DRAIN: ;
      ST_WB:    res_valid = 1'b1;
      default: ;
    endcase
  end

  // Scan bookkeeping. The compare stage works on the read address of the cycle
  // before, to line up with the RAM's registered read data.
  always_comb begin
    addr_nxt       = addr_r;
    cmp_en_nxt     = (state_r == ST_SCAN);
    cmp_addr_nxt   = addr_r;
    req_nxt        = req_r;
    hit_nxt        = hit_r;
    hit_handle_nxt = hit_handle_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    best_port_nxt  = best_port_r;

    if (req_valid && req_ready) begin
      addr_nxt = '0;
      req_nxt  = req;
      hit_nxt  = 1'b0;
      free_nxt = 1'b0;
      best_nxt = 1'b0;
    end else if (state_r == ST_SCAN) begin
      addr_nxt = scan_last ? '0 : addr_r + IDX_W'(1);
    end

    if (cmp_en_r) begin
      if (slot_valid && !hit_r && rd_entry.port == req_r.port) begin
        hit_nxt        = 1'b1;
        hit_handle_nxt = rd_entry.handle;
      end
      if (!slot_valid && !free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = cmp_addr_r;
      end
      if (slot_valid && rd_entry.handle == req_r.handle &&
          (!best_r || rd_entry.port < best_port_r)) begin
        best_nxt      = 1'b1;
        best_idx_nxt  = cmp_addr_r;
        best_port_nxt = rd_entry.port;
      end
    end
  end

  // Write-back and result.
  always_comb begin
    valid_nxt      = valid_r;
    ram_we         = 1'b0;
    res.status     = STAT_OK;
    res.found      = 1'b0;
    res.handle_out = '0;
    case (req_r.kind)
      KIND_LOOKUP: begin
        res.found = hit_r;
        if (hit_r) begin
          res.handle_out = OUT_HANDLE_W'(hit_handle_r);
        end
      end
      KIND_INSERT: begin
        if (!free_r) begin
          res.status = STAT_FULL;
        end else if (hit_r) begin
          res.status = STAT_DUP;
        end else if (wb_fire) begin
          ram_we              = 1'b1;
          valid_nxt[free_idx_r] = 1'b1;
        end
      end
      KIND_REMOVE: begin
        res.found = best_r;
        if (best_r && wb_fire) begin
          valid_nxt[best_idx_r] = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      valid_r  <= '0;
      cmp_en_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      cmp_en_r <= cmp_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    cmp_addr_r   <= cmp_addr_nxt;
    req_r        <= req_nxt;
    hit_r        <= hit_nxt;
    hit_handle_r <= hit_handle_nxt;
    free_r       <= free_nxt;
    free_idx_r   <= free_idx_nxt;
    best_r       <= best_nxt;
    best_idx_r   <= best_idx_nxt;
    best_port_r  <= best_port_nxt;
  end

endmodule

// ===== hdl/port_to_socket_table_top.sv =====
// A request is accepted only in the idle state; the engine then walks the single read port of
// the entry RAM once, one slot per cycle, passes a drain state and waits in the write-back
// state until the output register takes the result. No new request is taken before then.
// The output register holds a result while the next request is accepted and scanned.
// Reset: synchronous, active low; it clears every slot's valid bit at once, so the
// table is empty and ready in the first cycle after reset. No clearing pass is needed.
// ----------------------------------------------------------------------------
// port_to_socket_table_top
// UDP port to socket handle table with lookup, insert and remove requests.
// ----------------------------------------------------------------------------
module port_to_socket_table_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata: port [15:0], socket_handle [47:16]
  input  logic [pts_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: kind [1:0]
  input  logic [pts_pkg::KIND_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata: status [1:0], found [2], handle_out [34:3], zero [39:35]
  output logic [pts_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pts_pkg::*;

  pts_req_t    req;
  pts_result_t res;
  logic        res_valid;
  logic        res_ready;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  assign req.kind   = pts_kind_t'(in_tuser);
  assign req.port   = in_tdata[PORT_W-1:0];
  assign req.handle = HANDLE_BITS'(in_tdata[PORT_W +: IN_HANDLE_W]);

  pts_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The output register accepts a new word when empty or being drained.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_data_nxt = OUT_TDATA_W'({res.handle_out, res.found, res.status});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // A request keeps the engine busy for a whole scan.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while a scan was running");

  // A result never arrives right after a request is taken.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !(res_valid && res_ready))
    else $error("result produced without a table scan");

  // A match only ever comes with an ok status.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[STATUS_W]) |-> (out_tdata[STATUS_W-1:0] == STAT_OK))
    else $error("found flag set on a rejected request");

  // A result is never dropped by the output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !res_ready)
    else $error("pending result would be overwritten");
`endif

endmodule

// ===== test/pts_table_checker.sv =====
// ----------------------------------------------------------------------------
// pts_table_checker
// Watches both streams of the port to socket table. It keeps its own copy of
// the table, works out the result word for each accepted request, and compares
// every accepted result word field by field with the oldest one outstanding.
// ----------------------------------------------------------------------------
module pts_table_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // tdata: port [15:0], socket_handle [47:16]
  input  logic [pts_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: kind [1:0]
  input  logic [pts_pkg::KIND_W-1:0]      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata: status [1:0], found [2], handle_out [34:3], zero [39:35]
  input  logic [pts_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              mismatches,
  output int                              outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  import pts_pkg::*;

  logic                   slot_used   [TABLE_ENTRIES];
  logic [PORT_W-1:0]      slot_port   [TABLE_ENTRIES];
  logic [HANDLE_BITS-1:0] slot_handle [TABLE_ENTRIES];

  pts_result_t awaited_results[$];

  // Applies one request to the shadow table and returns the result word.
  function automatic pts_result_t table_apply(pts_kind_t kind, logic [PORT_W-1:0] port,
                                              logic [IN_HANDLE_W-1:0] handle);
    pts_result_t            res;
    int                     hit;
    int                     free_slot;
    int                     lowest;
    logic [HANDLE_BITS-1:0] key;
    res.status     = STAT_OK;
    res.found      = 1'b0;
    res.handle_out = '0;
    key       = HANDLE_BITS'(handle);
    hit       = -1;
    free_slot = -1;
    lowest    = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot_used[i] && slot_port[i] == port && hit < 0) hit = i;
      if (!slot_used[i] && free_slot < 0) free_slot = i;
      // Ports are unique, so the lowest port holding the handle is well defined.
      if (slot_used[i] && slot_handle[i] == key &&
          (lowest < 0 || slot_port[i] < slot_port[lowest])) lowest = i;
    end
    case (kind)
      KIND_LOOKUP: begin
        if (hit >= 0) begin
          res.found      = 1'b1;
          res.handle_out = OUT_HANDLE_W'(slot_handle[hit]);
        end
      end
      KIND_INSERT: begin
        // A full table answers full even when the port is already present.
        if (free_slot < 0) begin
          res.status = STAT_FULL;
        end else if (hit >= 0) begin
          res.status = STAT_DUP;
        end else begin
          slot_used[free_slot]   = 1'b1;
          slot_port[free_slot]   = port;
          slot_handle[free_slot] = key;
        end
      end
      KIND_REMOVE: begin
        if (lowest >= 0) begin
          res.found         = 1'b1;
          slot_used[lowest] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%t: result word %s mismatch: expected %0h, got %0h", $realtime, field, want, got);
  endtask

  always @(posedge clk) begin
    pts_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) slot_used[i] = 1'b0;
      awaited_results.delete();
      outstanding = 0;
      mismatches  = 0;
    end else begin
      // A result never leaves while its own request is being taken, so checking before
      // predicting within one edge never pairs a word with its own request.
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: result word %0h arrived with none outstanding", $realtime,
                     out_tdata);
        end else begin
          want = awaited_results.pop_front();
          if (out_tdata[1:0] != want.status)
            note_mismatch("status", 64'(want.status), 64'(out_tdata[1:0]));
          if (out_tdata[2] != want.found)
            note_mismatch("found", 64'(want.found), 64'(out_tdata[2]));
          if (out_tdata[34:3] != want.handle_out)
            note_mismatch("handle_out", 64'(want.handle_out), 64'(out_tdata[34:3]));
          if (out_tdata[OUT_TDATA_W-1:35] != '0)
            note_mismatch("padding", 64'd0, 64'(out_tdata[OUT_TDATA_W-1:35]));
        end
      end
      if (in_tvalid && in_tready)
        awaited_results.push_back(table_apply(pts_kind_t'(in_tuser), in_tdata[15:0],
                                              in_tdata[47:16]));
      outstanding = awaited_results.size();
    end
  end

endmodule

// ===== test/tb_port_to_socket_table_top.sv =====
// ----------------------------------------------------------------------------
// tb_port_to_socket_table_top
// Drives lookup, insert and remove requests into the port to socket table:
// a directed opening, then phases that fill, churn and drain the table, with
// bursty input, a randomly stalling receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_port_to_socket_table_top;

  timeunit 1ns;
  timeprecision 1ps;

  import pts_pkg::*;

  localparam int RANDOM_WORDS = 1250;
  localparam int PHASES       = 10;
  localparam int PORT_POOL    = 80;
  localparam int HANDLE_POOL  = 12;
  localparam int LONG_HOLD    = 600;

  typedef enum int {
    MIX_FILL,
    MIX_CHURN,
    MIX_DRAIN
  } req_mix_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [KIND_W-1:0]      in_tuser   = KIND_LOOKUP;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int  mismatches;
  int  outstanding;
  int  burst_left;
  bit  hold_request = 1'b0;

  logic [PORT_W-1:0]      port_pool   [PORT_POOL];
  logic [IN_HANDLE_W-1:0] handle_pool [HANDLE_POOL];

  port_to_socket_table_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  pts_table_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("** port_to_socket_table_top: FAILED **");
    $finish;
  end

  // The receiver switches between ready patterns, and on request holds off
  // for a long stretch so that the block backs up into its input.
  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(posedge clk);
        if (hold_request) begin
          hold_request = 1'b0;
          out_tready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end else begin
          case (mode)
            0: out_tready <= 1'b1;
            1: out_tready <= 1'($urandom_range(0, 1));
            2: out_tready <= ($urandom_range(0, 9) != 0);
            default: out_tready <= ($urandom_range(0, 9) == 0);
          endcase
        end
      end
    end
  end

  function automatic int next_burst();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
  endfunction

  task automatic put_word(pts_kind_t kind, logic [PORT_W-1:0] port,
                          logic [IN_HANDLE_W-1:0] handle);
    in_tuser  <= kind;
    in_tdata  <= {handle, port};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      // Long gaps land on every phase of the table scan.
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 6))
        @(posedge clk);
      burst_left = next_burst();
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = next_burst();
    @(posedge clk);
    wait (outstanding == 0);
  endtask

  function automatic logic [PORT_W-1:0] pick_port();
    return ($urandom_range(0, 3) != 0) ? port_pool[$urandom_range(0, PORT_POOL - 1)]
                                       : PORT_W'($urandom);
  endfunction

  function automatic logic [IN_HANDLE_W-1:0] pick_handle();
    return ($urandom_range(0, 3) != 0) ? handle_pool[$urandom_range(0, HANDLE_POOL - 1)]
                                       : IN_HANDLE_W'($urandom);
  endfunction

  function automatic pts_kind_t pick_kind(req_mix_t mix);
    int roll;
    int insert_cut;
    int lookup_cut;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin insert_cut = 80; lookup_cut = 93; end
      MIX_CHURN: begin insert_cut = 35; lookup_cut = 68; end
      default:   begin insert_cut = 15; lookup_cut = 35; end
    endcase
    if (roll < insert_cut) return KIND_INSERT;
    if (roll < lookup_cut) return KIND_LOOKUP;
    if (roll < 98) return KIND_REMOVE;
    return KIND_NONE;
  endfunction

  initial begin
    req_mix_t mix;
    port_pool[0]   = '0;
    port_pool[1]   = '1;
    handle_pool[0] = '0;
    handle_pool[1] = '1;
    for (int i = 2; i < PORT_POOL; i++) port_pool[i] = PORT_W'($urandom);
    for (int i = 2; i < HANDLE_POOL; i++) handle_pool[i] = IN_HANDLE_W'($urandom);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    burst_left = next_burst();

    // Extremes, duplicates, shared handles, handle zero and the unused kind.
    put_word(KIND_LOOKUP, 16'h0000, 32'h0000_0000);
    put_word(KIND_INSERT, 16'h0000, 32'h0000_0000);
    put_word(KIND_INSERT, 16'hffff, 32'hffff_ffff);
    put_word(KIND_INSERT, 16'h1234, 32'hffff_ffff);
    put_word(KIND_INSERT, 16'h0000, 32'h0000_0005);
    put_word(KIND_LOOKUP, 16'h0000, 32'h5555_5555);
    put_word(KIND_LOOKUP, 16'hffff, 32'haaaa_aaaa);
    put_word(KIND_LOOKUP, 16'h0001, 32'h0000_0000);
    put_word(KIND_REMOVE, 16'hffff, 32'hffff_ffff);
    put_word(KIND_LOOKUP, 16'h1234, 32'h0000_0000);
    put_word(KIND_LOOKUP, 16'hffff, 32'h0000_0000);
    put_word(KIND_REMOVE, 16'h0000, 32'hdead_beef);
    put_word(KIND_REMOVE, 16'h5a5a, 32'h0000_0000);
    put_word(KIND_LOOKUP, 16'h0000, 32'h0000_0000);
    put_word(KIND_NONE,   16'hffff, 32'hffff_ffff);
    put_word(KIND_LOOKUP, 16'hffff, 32'h0000_0000);
    put_word(KIND_REMOVE, 16'h0000, 32'hffff_ffff);
    put_word(KIND_REMOVE, 16'h0000, 32'hffff_ffff);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      mix = req_mix_t'(ph % 3);
      for (int n = 0; n < RANDOM_WORDS / PHASES; n++) begin
        if (ph == 4 && n == 30) hold_request = 1'b1;
        put_word(pick_kind(mix), pick_port(), pick_handle());
      end
      if (ph % 2 == 1) wait_drained();
    end

    wait_drained();
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("** port_to_socket_table_top: PASSED **");
    end else begin
      $display("** port_to_socket_table_top: FAILED **");
    end
    $finish;
  end

endmodule
